// ===== sv/ackcw_pkg.sv =====
// Package for the ACK-driven congestion window.
// Holds register indexes, reset values and fixed-point constants.
// No dependencies.
package ackcw_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_WINDOW     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_INIT_THRESHOLD = CSR_IDX_W'(1);

   // Register reset values, in whole packets
   localparam logic [15:0] MAX_WINDOW_RST     = 16'd64;
   localparam logic [15:0] INIT_THRESHOLD_RST = 16'd32;

   // Q16.16 one
   localparam logic [31:0] Q_ONE = 32'h0001_0000;

   // Ahead count value that triggers the halving on the next ahead ACK
   localparam logic [1:0] AHEAD_LAST = 2'd2;

   // Reciprocal divider: 2^32 / window, one quotient bit per step
   localparam int DIV_STEPS = 33;
   localparam int DIV_CNT_W = 6;

   // Command codes
   localparam logic CMD_ACK     = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

endpackage

// ===== sv/ackcw_if.sv =====
// Channel interfaces for the ACK-driven congestion window.
// Event request, result and configuration write channels.
// Depends on ackcw_pkg.
interface ackcw_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] ack_checksum;
   logic [15:0] ack_length;
   logic [31:0] ack_number;
   logic [12:0] base_seq;

   modport source (output valid, command, ack_checksum, ack_length, ack_number,
                   base_seq, input ready);
   modport sink   (input valid, command, ack_checksum, ack_length, ack_number,
                   base_seq, output ready);
endinterface

interface ackcw_rsp_if;
   logic        valid;
   logic        ready;
   logic        checksum_ok;
   logic [31:0] window_now;
   logic [31:0] threshold_now;
   logic        growth_mode;
   logic        window_halved;
   logic        ack_out_of_range;

   modport source (output valid, checksum_ok, window_now, threshold_now, growth_mode,
                   window_halved, ack_out_of_range, input ready);
   modport sink   (input valid, checksum_ok, window_now, threshold_now, growth_mode,
                   window_halved, ack_out_of_range, output ready);
endinterface

interface ackcw_csr_if import ackcw_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [15:0]          data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/ackcw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the acknowledged-packet bitmap. No dependencies.
module ackcw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ackcw_recip.sv =====
// Serial reciprocal unit: quotient = floor(2^32 / divisor), one bit per cycle.
// Restoring division over the 33 dividend bits. Depends on ackcw_pkg.
module ackcw_recip import ackcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [32:0] quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [31:0]          rem_ff;
   logic [32:0]          quot_ff;
   logic [31:0]          divisor_ff;

   logic        bit_in;
   logic [32:0] rem_sh;
   logic [32:0] diff;
   logic        ge;

   // One restoring step: the dividend is a single one followed by zeros
   always_comb begin
      bit_in = (count_ff == '0);
      rem_sh = {rem_ff, bit_in};
      diff   = rem_sh - {1'b0, divisor_ff};
      ge     = (rem_sh >= {1'b0, divisor_ff});
   end

   // Sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff    <= 1'b1;
            count_ff   <= '0;
            rem_ff     <= '0;
            quot_ff    <= '0;
            divisor_ff <= divisor;
         end else if (busy_ff) begin
            rem_ff   <= ge ? diff[31:0] : rem_sh[31:0];
            quot_ff  <= {quot_ff[31:0], ge};
            count_ff <= count_ff + 1'b1;
            if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== sv/ack_driven_congestion_window.sv =====
// Top level of the ACK-driven congestion window of a selective-repeat sender.
// Depends on ackcw_pkg, ackcw_if, ackcw_ram and ackcw_recip.
//
//   channel   dir   handshake          beat contents
//   req_ch    in    valid / ready      command, checksum, length, ack number, base number
//   rsp_ch    out   valid / ready      checksum_ok, window, threshold, mode, flags
//   csr_ch    in    valid / ready      register index, 16-bit write data
//
// An ACK that grows the window in fractional mode goes from lookup through the
// 33-step serial reciprocal divider and an add step to finish; other ACKs go from
// lookup straight to finish, a timeout from idle straight to finish.
// After reset a clearing pass zeroes the bitmap RAM, one entry per cycle; req_ch
// is not ready meanwhile, csr_ch always is.
// One event is in work at a time; the result register lets the next request
// beat in while a result still waits on rsp_ch, but a finished event holds in
// its last step until the result register is free.
module ack_driven_congestion_window import ackcw_pkg::*; #(
   parameter int MAX_PACKETS = 4096
) (
   input  logic       clock,
   input  logic       reset,
   ackcw_req_if.sink  req_ch,
   ackcw_rsp_if.source rsp_ch,
   ackcw_csr_if.sink  csr_ch
);

   localparam int ADDR_W = $clog2(MAX_PACKETS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_DIV,
      ST_ADD,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // Configuration and congestion state
   logic [15:0]       max_window_ff;
   logic [31:0]       threshold_ff;
   logic [31:0]       window_ff;
   logic              mode_ff;
   logic [1:0]        ahead_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // Event in work
   logic              ok_ff;
   logic              oor_ff;
   logic              gt_ff;
   logic              halved_ff;
   logic [ADDR_W-1:0] idx_ff;

   // Result register
   logic        rsp_valid_ff;
   logic        rsp_ok_ff;
   logic [31:0] rsp_window_ff;
   logic [31:0] rsp_threshold_ff;
   logic        rsp_mode_ff;
   logic        rsp_halved_ff;
   logic        rsp_oor_ff;

   // Handshakes
   logic req_fire;
   logic csr_fire;

   // Checksum
   logic [17:0] cks_sum;
   logic [16:0] cks_fold1;
   logic [16:0] cks_fold2;
   logic        cks_ok;
   logic        num_oor;
   logic        num_gt;

   // Lookup stage
   logic              map_bit;
   logic              halve_now;
   logic [31:0]       win_half;
   logic [31:0]       win_floor;
   logic              new_mark;
   logic              grow_now;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_wr_data;

   // Growth
   logic        div_start;
   logic        div_done;
   logic [32:0] div_quot;
   logic [33:0] grow_sum;
   logic [31:0] grow_win;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign csr_fire     = csr_ch.valid & csr_ch.ready;

   // Fold the ones'-complement sum of length and both halves of the number
   always_comb begin
      cks_sum   = 18'(req_ch.ack_length) + 18'(req_ch.ack_number[15:0])
                + 18'(req_ch.ack_number[31:16]);
      cks_fold1 = 17'(cks_sum[15:0]) + 17'(cks_sum[17:16]);
      cks_fold2 = 17'(cks_fold1[15:0]) + 17'(cks_fold1[16]);
      cks_ok    = (~cks_fold2[15:0] == req_ch.ack_checksum);
      num_oor   = ({1'b0, req_ch.ack_number} >= 33'(MAX_PACKETS));
      num_gt    = (req_ch.ack_number > 32'(req_ch.base_seq));
   end

   // Decide halving and marking once the bitmap bit is back
   always_comb begin
      halve_now = ok_ff & gt_ff & (ahead_ff == AHEAD_LAST);
      win_half  = window_ff >> 1;
      win_floor = (win_half <= Q_ONE) ? Q_ONE : win_half;
      new_mark  = ok_ff & ~oor_ff & ~map_bit;
      grow_now  = new_mark & ~halve_now;
      div_start = (state_ff == ST_LOOKUP) & grow_now & ~mode_ff;
   end

   // Bitmap writes: clearing pass, then marks
   always_comb begin
      ram_wr_en   = (state_ff == ST_CLEAR) | ((state_ff == ST_LOOKUP) & new_mark);
      ram_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : idx_ff;
      ram_wr_data = (state_ff != ST_CLEAR);
   end

   // Saturating fractional growth
   always_comb begin
      grow_sum = {2'b00, window_ff} + {1'b0, div_quot};
      grow_win = (grow_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : grow_sum[31:0];
   end

   ackcw_ram #(
      .WIDTH (1),
      .DEPTH (MAX_PACKETS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_ch.ack_number[ADDR_W-1:0]),
      .rd_data (map_bit)
   );

   ackcw_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (window_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Sequencer, state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         max_window_ff <= MAX_WINDOW_RST;
         threshold_ff  <= {INIT_THRESHOLD_RST, 16'h0000};
         window_ff     <= Q_ONE;
         mode_ff       <= 1'b0;
         ahead_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Configuration writes
         if (csr_fire) begin
            case (csr_ch.index)
               REG_MAX_WINDOW: begin
                  max_window_ff <= csr_ch.data;
               end
               REG_INIT_THRESHOLD: begin
                  threshold_ff <= {csr_ch.data, 16'h0000};
               end
               default: begin
               end
            endcase
         end

         // Drop the result once taken, unless a new one loads in its place
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == ADDR_W'(MAX_PACKETS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  idx_ff    <= req_ch.ack_number[ADDR_W-1:0];
                  halved_ff <= 1'b0;
                  if (req_ch.command == CMD_TIMEOUT) begin
                     ok_ff  <= 1'b0;
                     oor_ff <= 1'b0;
                     gt_ff  <= 1'b0;
                     if (window_ff > Q_ONE) begin
                        threshold_ff <= window_ff >> 1;
                        window_ff    <= Q_ONE;
                        mode_ff      <= 1'b0;
                     end
                     state_ff <= ST_FINISH;
                  end else begin
                     ok_ff    <= cks_ok;
                     oor_ff   <= num_oor;
                     gt_ff    <= num_gt;
                     state_ff <= ST_LOOKUP;
                  end
               end
            end
            ST_LOOKUP: begin
               halved_ff <= halve_now;
               if (ok_ff && gt_ff) begin
                  ahead_ff <= halve_now ? 2'd0 : ahead_ff + 1'b1;
               end
               if (halve_now) begin
                  window_ff <= win_floor;
                  mode_ff   <= (win_floor > threshold_ff);
               end
               if (grow_now && !mode_ff) begin
                  state_ff <= ST_DIV;
               end else begin
                  if (grow_now && (window_ff < {max_window_ff, 16'h0000})) begin
                     window_ff <= window_ff + Q_ONE;
                  end
                  state_ff <= ST_FINISH;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: begin
               window_ff <= grow_win;
               if (grow_win > threshold_ff) begin
                  mode_ff <= 1'b1;
               end
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               // Load the result register once it is free
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_ok_ff        <= ok_ff;
                  rsp_window_ff    <= window_ff;
                  rsp_threshold_ff <= threshold_ff;
                  rsp_mode_ff      <= mode_ff;
                  rsp_halved_ff    <= halved_ff;
                  rsp_oor_ff       <= oor_ff;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.checksum_ok      = rsp_ok_ff;
   assign rsp_ch.window_now       = rsp_window_ff;
   assign rsp_ch.threshold_now    = rsp_threshold_ff;
   assign rsp_ch.growth_mode      = rsp_mode_ff;
   assign rsp_ch.window_halved    = rsp_halved_ff;
   assign rsp_ch.ack_out_of_range = rsp_oor_ff;

endmodule

// ===== dv/ack_driven_congestion_window_tb.sv =====
// Self-checking testbench for the ACK-driven congestion window.
// Drives directed and random ACK and timeout beats, predicts every result beat.
// Depends on ackcw_pkg, ackcw_if and the ack_driven_congestion_window RTL.
module ack_driven_congestion_window_tb;
   import ackcw_pkg::*;

   localparam int NUM_PACKETS  = 4096;
   localparam int LIMIT_CYCLES = 800_000;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic        command;
      logic [15:0] ack_checksum;
      logic [15:0] ack_length;
      logic [31:0] ack_number;
      logic [12:0] base_seq;
   } ack_event_type;

   typedef struct packed {
      logic        checksum_ok;
      logic [31:0] window_now;
      logic [31:0] threshold_now;
      logic        growth_mode;
      logic        window_halved;
      logic        ack_out_of_range;
   } cw_outcome_type;

   typedef struct {
      ack_event_type  ev;
      bit             typed;
      cw_outcome_type want;
   } stim_row_type;

   typedef struct {
      logic [15:0] max_win;
      logic [15:0] init_thr;
      int          ahead_pct;
      int          send_idle;
      int          recv_idle;
      int          count;
   } phase_type;

   logic clock;
   logic reset;

   ackcw_req_if req_ch();
   ackcw_rsp_if rsp_ch();
   ackcw_csr_if csr_ch();

   ack_driven_congestion_window u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow state of the window logic
   logic [31:0] cw_window;
   logic [31:0] cw_threshold;
   logic        cw_mode;
   logic [1:0]  cw_ahead;
   bit          cw_acked [NUM_PACKETS];
   logic [15:0] cw_max;

   cw_outcome_type pending_outcomes[$];
   stim_row_type   row_q[$];
   int             fault_count;
   int             results_seen;
   int             send_idle_pct;
   int             recv_idle_pct;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog
   initial begin
      #(LIMIT_CYCLES * 8);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic void note_fault(string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("%s", msg);
   endfunction

   // Ones'-complement checksum over zero, length and both halves of the number
   function automatic logic [15:0] ack_checksum_of(logic [15:0] len, logic [31:0] num);
      logic [31:0] s;
      s = 32'(len) + 32'(num[15:0]) + 32'(num[31:16]);
      s = (s & 32'h0000_FFFF) + (s >> 16);
      s = (s & 32'h0000_FFFF) + (s >> 16);
      return ~s[15:0];
   endfunction

   // Advance the shadow state by one event and return the result beat
   function automatic cw_outcome_type step_window(ack_event_type e);
      cw_outcome_type   o;
      longint unsigned  grown;
      o = '0;
      if (e.command == CMD_TIMEOUT) begin
         // cut to one packet unless already there
         if (cw_window > Q_ONE) begin
            cw_threshold = cw_window >> 1;
            cw_window    = Q_ONE;
            cw_mode      = 1'b0;
         end
      end else begin
         o.ack_out_of_range = (e.ack_number >= NUM_PACKETS);
         o.checksum_ok = (ack_checksum_of(e.ack_length, e.ack_number) == e.ack_checksum);
         if (o.checksum_ok) begin
            // third ahead ACK halves the window, floor of one packet
            if (e.ack_number > 32'(e.base_seq)) begin
               cw_ahead = cw_ahead + 2'd1;
               if (cw_ahead == 2'd3) begin
                  cw_window = cw_window >> 1;
                  if (cw_window <= Q_ONE)
                     cw_window = Q_ONE;
                  cw_mode         = (cw_window > cw_threshold);
                  cw_ahead        = 2'd0;
                  o.window_halved = 1'b1;
               end
            end
            // newly acknowledged packet grows the window
            if (!o.ack_out_of_range && !cw_acked[e.ack_number[11:0]]) begin
               cw_acked[e.ack_number[11:0]] = 1'b1;
               if (!o.window_halved) begin
                  if (!cw_mode) begin
                     grown = longint'(cw_window) + (64'h1_0000_0000 / cw_window);
                     cw_window = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
                     if (cw_window > cw_threshold)
                        cw_mode = 1'b1;
                  end else if (cw_window < {cw_max, 16'h0000}) begin
                     cw_window = cw_window + Q_ONE;
                  end
               end
            end
         end
      end
      o.window_now    = cw_window;
      o.threshold_now = cw_threshold;
      o.growth_mode   = cw_mode;
      return o;
   endfunction

   function automatic ack_event_type ack_ev(logic [15:0] len, logic [31:0] num,
                                            logic [12:0] base, bit good);
      ack_event_type e;
      e.command      = CMD_ACK;
      e.ack_length   = len;
      e.ack_number   = num;
      e.base_seq     = base;
      e.ack_checksum = ack_checksum_of(len, num) ^ (good ? 16'h0000 : 16'h0001);
      return e;
   endfunction

   function automatic void add_row(ack_event_type e, bit typed, cw_outcome_type want);
      stim_row_type r;
      r.ev    = e;
      r.typed = typed;
      r.want  = want;
      row_q.insert(row_q.size(), r);
   endfunction

   // Random beat: mostly well-formed ACKs, some timeouts and corrupted ones
   function automatic ack_event_type random_event(int ahead_pct);
      ack_event_type e;
      int unsigned   lim;
      int unsigned   pick;
      e = ack_ev(16'($urandom), 32'h0, 13'h0, 1'b1);
      pick = $urandom_range(99);
      if (pick < 60)
         e.ack_number = $urandom_range(NUM_PACKETS - 1);
      else if (pick < 75)
         e.ack_number = $urandom_range(31);
      else if (pick < 85)
         e.ack_number = NUM_PACKETS + $urandom_range(15);
      else
         e.ack_number = $urandom;
      lim = (e.ack_number > NUM_PACKETS) ? NUM_PACKETS : e.ack_number;
      if (e.ack_number == 0 || $urandom_range(99) >= ahead_pct)
         e.base_seq = 13'($urandom_range(NUM_PACKETS, lim));
      else if (e.ack_number > NUM_PACKETS)
         e.base_seq = 13'($urandom_range(NUM_PACKETS));
      else
         e.base_seq = 13'($urandom_range(lim - 1));
      e.ack_checksum = ack_checksum_of(e.ack_length, e.ack_number);
      if ($urandom_range(99) < 15)
         e.ack_checksum = e.ack_checksum ^ 16'($urandom_range(65535, 1));
      if ($urandom_range(99) < 7) begin
         e.command      = CMD_TIMEOUT;
         e.ack_checksum = 16'($urandom);
      end
      return e;
   endfunction

   // Offer every queued row on the request channel
   task automatic drive_rows();
      stim_row_type   r;
      cw_outcome_type predicted;
      while (row_q.size() != 0) begin
         r = row_q.pop_front();
         while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         req_ch.valid        <= 1'b1;
         req_ch.command      <= r.ev.command;
         req_ch.ack_checksum <= r.ev.ack_checksum;
         req_ch.ack_length   <= r.ev.ack_length;
         req_ch.ack_number   <= r.ev.ack_number;
         req_ch.base_seq     <= r.ev.base_seq;
         @(posedge clock);
         while (!req_ch.ready)
            @(posedge clock);
         predicted = step_window(r.ev);
         pending_outcomes.insert(pending_outcomes.size(), r.typed ? r.want : predicted);
      end
      req_ch.valid <= 1'b0;
   endtask

   // Write both registers back to back
   task automatic program_window(logic [15:0] max_win, logic [15:0] init_thr);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= REG_MAX_WINDOW;
      csr_ch.data  <= max_win;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      cw_max = max_win;
      csr_ch.index <= REG_INIT_THRESHOLD;
      csr_ch.data  <= init_thr;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      cw_threshold = {init_thr, 16'h0000};
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Result side: check each beat, stall at random, one long hold-off
   initial begin
      int             hold_left;
      bit             hold_done;
      cw_outcome_type got;
      cw_outcome_type want;
      string          exp_txt;
      string          got_txt;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.checksum_ok, rsp_ch.window_now, rsp_ch.threshold_now,
                   rsp_ch.growth_mode, rsp_ch.window_halved, rsp_ch.ack_out_of_range};
            results_seen++;
            if (pending_outcomes.size() == 0) begin
               note_fault($sformatf("unexpected result beat: %h", got));
            end else begin
               want = pending_outcomes.pop_front();
               if (got.checksum_ok !== want.checksum_ok ||
                   got.window_now !== want.window_now ||
                   got.threshold_now !== want.threshold_now ||
                   got.growth_mode !== want.growth_mode ||
                   got.window_halved !== want.window_halved ||
                   got.ack_out_of_range !== want.ack_out_of_range) begin
                  exp_txt = $sformatf(
                     "beat %0d: exp ok=%b win=%h thr=%h mode=%b half=%b oor=%b",
                     results_seen, want.checksum_ok, want.window_now, want.threshold_now,
                     want.growth_mode, want.window_halved, want.ack_out_of_range);
                  got_txt = $sformatf(
                     ", got ok=%b win=%h thr=%h mode=%b half=%b oor=%b",
                     got.checksum_ok, got.window_now, got.threshold_now,
                     got.growth_mode, got.window_halved, got.ack_out_of_range);
                  note_fault({exp_txt, got_txt});
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Main sequence
   initial begin
      phase_type phases[6];
      phases[0] = '{16'd64,    16'd32,    35, 27, 72, 250};
      phases[1] = '{16'd1,     16'd0,     30, 27, 72, 250};
      phases[2] = '{16'd65535, 16'd65535, 20, 72, 27, 250};
      phases[3] = '{16'd0,     16'd16,    30, 72, 27, 250};
      phases[4] = '{16'd200,   16'd8,     10,  0,  0, 270};
      phases[5] = '{16'd16,    16'd2,     40,  0,  0, 260};

      fault_count   = 0;
      results_seen  = 0;
      send_idle_pct = 27;
      recv_idle_pct = 72;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.command      = CMD_ACK;
      req_ch.ack_checksum = 16'h0;
      req_ch.ack_length   = 16'h0;
      req_ch.ack_number   = 32'h0;
      req_ch.base_seq     = 13'h0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = REG_MAX_WINDOW;
      csr_ch.data         = 16'h0;

      // Shadow reset
      cw_max       = MAX_WINDOW_RST;
      cw_window    = Q_ONE;
      cw_threshold = {INIT_THRESHOLD_RST, 16'h0000};
      cw_mode      = 1'b0;
      cw_ahead     = 2'd0;
      foreach (cw_acked[i])
         cw_acked[i] = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table, reset register values
      // timeout at minimum window leaves everything as is
      add_row('{CMD_TIMEOUT, 16'h0, 16'h0, 32'h0, 13'h0}, 1'b1,
              '{1'b0, Q_ONE, 32'h0020_0000, 1'b0, 1'b0, 1'b0});
      // bad checksum, in range and out of range
      add_row(ack_ev(16'h1234, 32'd5, 13'd0, 1'b0), 1'b1,
              '{1'b0, Q_ONE, 32'h0020_0000, 1'b0, 1'b0, 1'b0});
      add_row(ack_ev(16'h0040, 32'hFFFF_FFFF, 13'd0, 1'b0), 1'b1,
              '{1'b0, Q_ONE, 32'h0020_0000, 1'b0, 1'b0, 1'b1});
      // first new packet doubles the window from one, then a repeated ACK
      add_row(ack_ev(16'h0010, 32'd1, 13'd1, 1'b1), 1'b1,
              '{1'b1, 32'h0002_0000, 32'h0020_0000, 1'b0, 1'b0, 1'b0});
      add_row(ack_ev(16'h0010, 32'd1, 13'd1, 1'b1), 1'b1,
              '{1'b1, 32'h0002_0000, 32'h0020_0000, 1'b0, 1'b0, 1'b0});
      // three ahead ACKs, the middle one out of range, the last halves
      add_row(ack_ev(16'h0020, 32'd2, 13'd0, 1'b1), 1'b0, '0);
      add_row(ack_ev(16'hFFFF, 32'hFFFF_FFFF, 13'd0, 1'b1), 1'b0, '0);
      add_row(ack_ev(16'h0020, 32'd3, 13'd0, 1'b1), 1'b0, '0);
      // field extremes: checksum 0 and FFFF, number 0, last in range and out of range
      add_row(ack_ev(16'hFFFF, 32'd0, 13'd0, 1'b1), 1'b0, '0);
      add_row(ack_ev(16'h0000, 32'd4095, 13'd4095, 1'b1), 1'b0, '0);
      add_row(ack_ev(16'h5555, 32'd4096, 13'd4096, 1'b1), 1'b0, '0);
      add_row(ack_ev(16'hAAAA, 32'h8000_0000, 13'd4096, 1'b1), 1'b0, '0);
      add_row(ack_ev(16'h0000, 32'd0, 13'd0, 1'b1), 1'b0, '0);
      // timeout above one packet, then regrow into whole-packet mode
      add_row('{CMD_TIMEOUT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 13'd4096}, 1'b0, '0);
      add_row(ack_ev(16'h0100, 32'd10, 13'd4096, 1'b1), 1'b0, '0);
      add_row(ack_ev(16'h0100, 32'd11, 13'd4096, 1'b1), 1'b0, '0);
      add_row(ack_ev(16'h0100, 32'd12, 13'd4096, 1'b1), 1'b0, '0);
      add_row(ack_ev(16'h0100, 32'd13, 13'd4096, 1'b1), 1'b0, '0);
      add_row(ack_ev(16'h0200, 32'd20, 13'd19, 1'b1), 1'b0, '0);
      add_row(ack_ev(16'h0200, 32'd21, 13'd0, 1'b1), 1'b0, '0);
      add_row('{CMD_TIMEOUT, 16'h0, 16'h0, 32'h0, 13'h0}, 1'b0, '0);
      add_row('{CMD_TIMEOUT, 16'h0, 16'h0, 32'h0, 13'h0}, 1'b0, '0);
      drive_rows();
      wait_drained();

      // Random phases, each with its own register setting and idle pattern
      foreach (phases[p]) begin
         send_idle_pct = phases[p].send_idle;
         recv_idle_pct = phases[p].recv_idle;
         program_window(phases[p].max_win, phases[p].init_thr);
         repeat (phases[p].count)
            add_row(random_event(phases[p].ahead_pct), 1'b0, '0);
         drive_rows();
         wait_drained();
      end

      // Let any late beat show up, then judge
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0)
         note_fault($sformatf("%0d results never arrived", pending_outcomes.size()));
      if (fault_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ackcw_pkg.sv
sv/ackcw_if.sv
sv/ackcw_ram.sv
sv/ackcw_recip.sv
sv/ack_driven_congestion_window.sv
dv/ack_driven_congestion_window_tb.sv
